### rtl/core/src_pkg.sv
`timescale 1ns / 1ps

package src_pkg;

    // Record layout
    localparam int RECORD_BYTES = 40;
    localparam int CRC_BYTES    = RECORD_BYTES - 4;
    localparam int N_SETTINGS   = 6;
    localparam int POS_W        = 6;
    localparam int WORD_IDX_W   = 4;
    localparam int SET_IDX_W    = 3;

    localparam logic [POS_W-1:0]      LAST_POS      = POS_W'(RECORD_BYTES - 1);
    localparam logic [POS_W-1:0]      CRC_LAST_POS  = POS_W'(CRC_BYTES - 1);
    localparam logic [WORD_IDX_W-1:0] WORD_MAGIC    = WORD_IDX_W'(0);
    localparam logic [WORD_IDX_W-1:0] WORD_VERSION  = WORD_IDX_W'(1);
    localparam logic [WORD_IDX_W-1:0] WORD_SET_BASE = WORD_IDX_W'(2);
    localparam logic [WORD_IDX_W-1:0] WORD_SET_LAST = WORD_IDX_W'(2 + N_SETTINGS - 1);

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [31:0] MAGIC_RESET   = 32'h5546_3450;
    localparam logic [31:0] VERSION_RESET = 32'd1;
    localparam logic [31:0] FAN_RESET     = 32'd1000;

    // Register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_MAGIC   = 2'd0,
        CFG_EXPECTED_VERSION = 2'd1,
        CFG_FAN_LIMIT        = 2'd2
    } cfg_index_t;

    // Register values seen by the parser
    typedef struct packed {
        logic [31:0] expected_magic;
        logic [31:0] expected_version;
        logic [31:0] fan_limit;
    } cfg_t;

    // One finished record check
    typedef struct packed {
        logic                       ok;
        logic [N_SETTINGS-1:0][31:0] words;
    } result_t;

    // One byte through the reflected CRC-32, one bit per step.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/src_cfg_regs.sv
`timescale 1ns / 1ps

module src_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [src_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_wdata,
    output src_pkg::cfg_t                    cfg
);

    src_pkg::cfg_t cfg_reg;
    src_pkg::cfg_t cfg_next;

    // Decode the register index; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                src_pkg::CFG_EXPECTED_MAGIC:   cfg_next.expected_magic   = cfg_wdata;
                src_pkg::CFG_EXPECTED_VERSION: cfg_next.expected_version = cfg_wdata;
                src_pkg::CFG_FAN_LIMIT:        cfg_next.fan_limit        = cfg_wdata;
                default:                       cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic   <= src_pkg::MAGIC_RESET;
            cfg_reg.expected_version <= src_pkg::VERSION_RESET;
            cfg_reg.fan_limit        <= src_pkg::FAN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/src_parse.sv
`timescale 1ns / 1ps

module src_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data,
    input  src_pkg::cfg_t     cfg,
    output logic              last_byte,
    output src_pkg::result_t  result
);

    logic [src_pkg::POS_W-1:0]   pos_reg;
    logic [src_pkg::POS_W-1:0]   pos_next;
    logic [31:0]                 crc_reg;
    logic [31:0]                 crc_next;
    logic [31:0]                 word_reg;
    logic [31:0]                 word_next;
    logic                        header_ok_reg;
    logic                        header_ok_next;
    logic [31:0]                 settings_reg [src_pkg::N_SETTINGS];

    logic [src_pkg::WORD_IDX_W-1:0] word_idx;
    logic [src_pkg::WORD_IDX_W-1:0] set_offset;
    logic [src_pkg::SET_IDX_W-1:0]  set_idx;
    logic                           word_done;
    logic                           set_write;

    assign last_byte  = (pos_reg >= src_pkg::LAST_POS);
    assign word_idx   = pos_reg[src_pkg::POS_W-1:2];
    assign word_done  = (pos_reg[1:0] == 2'b11);
    assign set_offset = word_idx - src_pkg::WORD_SET_BASE;
    assign set_idx    = set_offset[src_pkg::SET_IDX_W-1:0];
    assign set_write  = step && word_done && (word_idx >= src_pkg::WORD_SET_BASE)
                        && (word_idx <= src_pkg::WORD_SET_LAST);

    // Byte position, CRC, word assembly and header check.
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        word_next      = {data, word_reg[31:8]};
        header_ok_next = header_ok_reg;

        if (pos_reg <= src_pkg::CRC_LAST_POS)
        begin
            crc_next = src_pkg::crc32_byte(crc_reg, data);
        end

        if (word_done && (word_idx == src_pkg::WORD_MAGIC)
            && (word_next != cfg.expected_magic))
        begin
            header_ok_next = 1'b0;
        end
        if (word_done && (word_idx == src_pkg::WORD_VERSION)
            && (word_next != cfg.expected_version))
        begin
            header_ok_next = 1'b0;
        end

        if (last_byte)
        begin
            pos_next       = '0;
            crc_next       = src_pkg::CRC_INIT;
            word_next      = '0;
            header_ok_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Final check, valid on the last byte of the record.
    always_comb
    begin
        result.ok = header_ok_reg
                    && ((crc_reg ^ src_pkg::CRC_INIT) == {data, word_reg[31:8]})
                    && (settings_reg[src_pkg::N_SETTINGS-1] <= cfg.fan_limit);
        for (int j = 0; j < src_pkg::N_SETTINGS; j++)
        begin
            result.words[j] = settings_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= src_pkg::CRC_INIT;
            word_reg      <= '0;
            header_ok_reg <= 1'b1;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            word_reg      <= word_next;
            header_ok_reg <= header_ok_next;
        end
    end

    // Setting words hold payload only.
    always_ff @(posedge clk)
    begin
        if (set_write)
        begin
            settings_reg[set_idx] <= {data, word_reg[31:8]};
        end
    end

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= src_pkg::LAST_POS)
        else $error("byte position beyond the record");

    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> pos_reg == '0 && header_ok_reg && crc_reg == src_pkg::CRC_INIT)
        else $error("parser did not restart after the last byte");

    a_crc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        step && (pos_reg > src_pkg::CRC_LAST_POS) && !last_byte |=> $stable(crc_reg))
        else $error("CRC changed over the stored CRC word");
`endif

endmodule

### rtl/core/src_out_stage.sv
`timescale 1ns / 1ps

module src_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  src_pkg::result_t  result,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              record_ok,
    output logic [31:0]       voltage_mv,
    output logic [31:0]       current_ma,
    output logic signed [31:0] temp_limit_mc,
    output logic [31:0]       volt_limit_mv,
    output logic [31:0]       amp_limit_ma,
    output logic [31:0]       fan_permille
);

    logic             valid_reg;
    logic             valid_next;
    src_pkg::result_t data_reg;

    // Hold the result until the request is taken.
    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid     = valid_reg;
    assign record_ok     = data_reg.ok;
    assign voltage_mv    = data_reg.words[0];
    assign current_ma    = data_reg.words[1];
    assign temp_limit_mc = signed'(data_reg.words[2]);
    assign volt_limit_mv = data_reg.words[3];
    assign amp_limit_ma  = data_reg.words[4];
    assign fan_permille  = data_reg.words[5];

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || out_ready)
        else $error("result register overwritten before it was taken");
`endif

endmodule

### rtl/core/settings_record_checker.sv
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// in        in_valid / in_ready      record_byte
// out       out_valid / out_ready    record_ok, voltage_mv .. fan_permille
// cfg       cfg_write_en             cfg_index, cfg_wdata
//
// One byte is taken per cycle unless the last byte stalls; each byte is held in the input
// register, and the record's result is loaded into the output register as the last byte moves on.
// The byte-wide CRC update and the word checks sit between those two registers.
// Reset zeroes the byte position, presets the CRC and header flag and restores the registers.
// Only the last byte of a record stalls, while the previous result is still held.

module settings_record_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       record_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             record_ok,
    output logic [31:0]                      voltage_mv,
    output logic [31:0]                      current_ma,
    output logic signed [31:0]               temp_limit_mc,
    output logic [31:0]                      volt_limit_mv,
    output logic [31:0]                      amp_limit_ma,
    output logic [31:0]                      fan_permille,
    input  logic                             cfg_write_en,
    input  logic [src_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_wdata
);

    logic             byte_valid_reg;
    logic             byte_valid_next;
    logic [7:0]       byte_reg;
    logic             last_byte;
    logic             slot_free;
    logic             advance;
    src_pkg::cfg_t    cfg;
    src_pkg::result_t result;

    // The held byte moves on unless it closes a record and the result slot is busy.
    assign slot_free = !out_valid || out_ready;
    assign advance   = byte_valid_reg && (!last_byte || slot_free);
    assign in_ready  = !byte_valid_reg || advance;

    always_comb
    begin
        byte_valid_next = byte_valid_reg && !advance;
        if (in_valid && in_ready)
        begin
            byte_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= record_byte;
        end
    end

    src_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg)
    );

    src_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data      (byte_reg),
        .cfg       (cfg),
        .last_byte (last_byte),
        .result    (result)
    );

    src_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && last_byte),
        .result        (result),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_ok     (record_ok),
        .voltage_mv    (voltage_mv),
        .current_ma    (current_ma),
        .temp_limit_mc (temp_limit_mc),
        .volt_limit_mv (volt_limit_mv),
        .amp_limit_ma  (amp_limit_ma),
        .fan_permille  (fan_permille)
    );

endmodule

### test/record_result_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels of the settings record checker, keeps
// its own copy of the record parser and compares every emitted result.
module record_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      record_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            record_ok,
    input  logic [31:0]                     voltage_mv,
    input  logic [31:0]                     current_ma,
    input  logic signed [31:0]              temp_limit_mc,
    input  logic [31:0]                     volt_limit_mv,
    input  logic [31:0]                     amp_limit_ma,
    input  logic [31:0]                     fan_permille,
    input  logic                            cfg_write_en,
    input  logic [src_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_wdata,
    output int                              fail_count,
    output int                              outstanding
);

    typedef struct packed {
        logic        ok;
        logic [31:0] voltage;
        logic [31:0] current;
        logic [31:0] temp_limit;
        logic [31:0] volt_limit;
        logic [31:0] amp_limit;
        logic [31:0] fan;
    } record_verdict_t;

    // Register copies, updated on every write the block sees.
    logic [31:0] magic_reg;
    logic [31:0] version_reg;
    logic [31:0] fan_limit_reg;

    // Parser state.
    logic [src_pkg::POS_W-1:0] byte_pos;
    logic [31:0]               crc_acc;
    logic [31:0]               word_shift;
    logic [31:0]               setting_word [src_pkg::N_SETTINGS];
    logic                      header_good;

    record_verdict_t  awaited_verdicts [$];
    record_verdict_t  want;
    int               mismatches = 0;

    // Back to the first byte of a fresh record.
    function automatic void restart_record();
        byte_pos    = '0;
        crc_acc     = src_pkg::CRC_INIT;
        word_shift  = '0;
        header_good = 1'b1;
    endfunction

    // Takes one record byte; a finished record queues its verdict.
    function automatic void absorb_byte(input logic [7:0] b);
        logic [src_pkg::POS_W-1:0]      p;
        logic [src_pkg::WORD_IDX_W-1:0] widx;
        record_verdict_t                v;
        int                             k;
        p = byte_pos;
        if (p >= src_pkg::LAST_POS)
            p = src_pkg::LAST_POS;

        // Bytes up to and including the padding word feed the CRC, LSB first.
        if (p <= src_pkg::CRC_LAST_POS)
        begin
            for (k = 0; k < 8; k++)
                crc_acc = (crc_acc[0] ^ b[k]) ? ((crc_acc >> 1) ^ src_pkg::CRC_POLY)
                                              : (crc_acc >> 1);
        end

        // Little-endian words assemble from the top down.
        word_shift = {b, word_shift[31:8]};

        if (p[1:0] == 2'd3)
        begin
            widx = p[src_pkg::POS_W-1:2];
            if (widx == src_pkg::WORD_MAGIC)
            begin
                if (word_shift != magic_reg)
                    header_good = 1'b0;
            end
            else if (widx == src_pkg::WORD_VERSION)
            begin
                if (word_shift != version_reg)
                    header_good = 1'b0;
            end
            else if (widx >= src_pkg::WORD_SET_BASE && widx <= src_pkg::WORD_SET_LAST)
            begin
                setting_word[widx - src_pkg::WORD_SET_BASE] = word_shift;
            end
        end

        if (p == src_pkg::LAST_POS)
        begin
            // The last word is the stored CRC; the fan limit is read now.
            v.ok = header_good && (~crc_acc == word_shift)
                   && (setting_word[src_pkg::N_SETTINGS-1] <= fan_limit_reg);
            v.voltage    = setting_word[0];
            v.current    = setting_word[1];
            v.temp_limit = setting_word[2];
            v.volt_limit = setting_word[3];
            v.amp_limit  = setting_word[4];
            v.fan        = setting_word[5];
            awaited_verdicts.push_back(v);
            restart_record();
        end
        else
        begin
            byte_pos = p + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected_val,
                                        input logic [31:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, name, expected_val, actual_val);
            mismatches++;
        end
    endfunction

    // Everything is sampled at the rising edge, before the block's outputs move.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     = src_pkg::MAGIC_RESET;
            version_reg   = src_pkg::VERSION_RESET;
            fan_limit_reg = src_pkg::FAN_RESET;
            for (int i = 0; i < src_pkg::N_SETTINGS; i++)
                setting_word[i] = '0;
            restart_record();
            awaited_verdicts.delete();
            outstanding <= 0;
            fail_count  <= mismatches;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    src_pkg::CFG_EXPECTED_MAGIC:   magic_reg     = cfg_wdata;
                    src_pkg::CFG_EXPECTED_VERSION: version_reg   = cfg_wdata;
                    src_pkg::CFG_FAN_LIMIT:        fan_limit_reg = cfg_wdata;
                    default: ;
                endcase
            end

            // Each accepted request is one record byte.
            if (in_valid && in_ready)
                absorb_byte(record_byte);

            if (out_valid && out_ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected record result: expected none, actual ok=%b",
                             $time, record_ok);
                    mismatches++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    check_field("record_ok",     {31'd0, want.ok}, {31'd0, record_ok});
                    check_field("voltage_mv",    want.voltage,     voltage_mv);
                    check_field("current_ma",    want.current,     current_ma);
                    check_field("temp_limit_mc", want.temp_limit,  temp_limit_mc);
                    check_field("volt_limit_mv", want.volt_limit,  volt_limit_mv);
                    check_field("amp_limit_ma",  want.amp_limit,   amp_limit_ma);
                    check_field("fan_permille",  want.fan,         fan_permille);
                end
            end

            outstanding <= awaited_verdicts.size();
            fail_count  <= mismatches;
        end
    end

endmodule

### test/settings_record_checker_tb.sv
`timescale 1ns / 1ps

module settings_record_checker_tb;

    localparam logic [src_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int RANDOM_RECORDS = 38;

    typedef enum int {
        REC_GOOD,
        REC_FAN_HIGH,
        REC_BAD_CRC,
        REC_BAD_MAGIC,
        REC_BAD_VERSION,
        REC_NOISE
    } record_kind_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      record_byte = 8'd0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            record_ok;
    logic [31:0]                     voltage_mv;
    logic [31:0]                     current_ma;
    logic signed [31:0]              temp_limit_mc;
    logic [31:0]                     volt_limit_mv;
    logic [31:0]                     amp_limit_ma;
    logic [31:0]                     fan_permille;
    logic                            cfg_write_en = 1'b0;
    logic [src_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                     cfg_wdata = '0;
    int                              fail_count;
    int                              outstanding;

    // Register values as last written, used to build records.
    logic [31:0] cur_magic     = src_pkg::MAGIC_RESET;
    logic [31:0] cur_version   = src_pkg::VERSION_RESET;
    logic [31:0] cur_fan_limit = src_pkg::FAN_RESET;

    // Ten little-endian words of the record being sent.
    logic [31:0] rec_word [src_pkg::RECORD_BYTES/4];

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int ready_hold = 0;

    settings_record_checker dut (.*);
    record_result_checker   checker_inst (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (!rx_stalls)
        begin
            out_ready <= 1'b1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Random word that lands on the extremes fairly often.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_reg_value(input logic [31:0] reset_val);
        case ($urandom_range(0, 4))
            0:       return reset_val;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic record_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return REC_GOOD;
        else if (r < 65) return REC_FAN_HIGH;
        else if (r < 75) return REC_BAD_CRC;
        else if (r < 83) return REC_BAD_MAGIC;
        else if (r < 91) return REC_BAD_VERSION;
        else             return REC_NOISE;
    endfunction

    // Stored CRC for the first 36 bytes of the record.
    function automatic logic [31:0] record_crc();
        logic [31:0] c;
        logic [7:0]  b;
        int          n;
        int          k;
        c = src_pkg::CRC_INIT;
        for (n = 0; n < src_pkg::CRC_BYTES; n++)
        begin
            b = rec_word[n/4][8*(n%4) +: 8];
            for (k = 0; k < 8; k++)
                c = (c[0] ^ b[k]) ? ((c >> 1) ^ src_pkg::CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    task automatic set_settings(input logic [31:0] volt, input logic [31:0] amp,
                                input logic [31:0] temp, input logic [31:0] ovp,
                                input logic [31:0] ocp, input logic [31:0] fan,
                                input logic [31:0] pad);
        rec_word[2] = volt;
        rec_word[3] = amp;
        rec_word[4] = temp;
        rec_word[5] = ovp;
        rec_word[6] = ocp;
        rec_word[7] = fan;
        rec_word[8] = pad;
    endtask

    // Random setting words; the fan word is placed relative to the limit.
    task automatic fill_settings(input record_kind_t kind);
        logic [63:0] span;
        logic [31:0] fan;
        if (kind == REC_FAN_HIGH && cur_fan_limit != 32'hFFFF_FFFF)
        begin
            span = 64'h0000_0000_FFFF_FFFF - {32'd0, cur_fan_limit};
            case ($urandom_range(0, 3))
                0:       fan = cur_fan_limit + 1;
                1:       fan = 32'hFFFF_FFFF;
                default: fan = cur_fan_limit + 1 + 32'({32'd0, $urandom} % span);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       fan = cur_fan_limit;
                1:       fan = 32'd0;
                default: fan = 32'({32'd0, $urandom} % ({32'd0, cur_fan_limit} + 64'd1));
            endcase
        end
        set_settings(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     fan, $urandom);
    endtask

    // Header and CRC words, with one fault injected where the kind asks; a noise record is all random.
    task automatic seal_record(input record_kind_t kind);
        if (kind == REC_NOISE)
        begin
            for (int w = 0; w < src_pkg::RECORD_BYTES/4; w++)
                rec_word[w] = $urandom;
        end
        else
        begin
            rec_word[0] = cur_magic;
            rec_word[1] = cur_version;
            if (kind == REC_BAD_MAGIC)
                rec_word[0] ^= 32'd1 << $urandom_range(0, 31);
            if (kind == REC_BAD_VERSION)
                rec_word[1] ^= 32'd1 << $urandom_range(0, 31);
            rec_word[9] = record_crc();
            if (kind == REC_BAD_CRC)
                rec_word[9] ^= 32'd1 << $urandom_range(0, 31);
        end
    endtask

    // Offers one byte and returns at the edge where the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        record_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [src_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= data;
        @(posedge clk);
    endtask

    // Drain the block, then write all three registers and reshuffle the idling.
    task automatic reconfigure(input logic [31:0] magic, input logic [31:0] version,
                               input logic [31:0] fan_limit);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED_INDEX, $urandom);
        write_reg(src_pkg::CFG_EXPECTED_MAGIC, magic);
        write_reg(src_pkg::CFG_EXPECTED_VERSION, version);
        write_reg(src_pkg::CFG_FAN_LIMIT, fan_limit);
        cfg_write_en  <= 1'b0;
        cur_magic     = magic;
        cur_version   = version;
        cur_fan_limit = fan_limit;
        tx_gaps       = ($urandom_range(0, 3) != 0);
        rx_stalls     = ($urandom_range(0, 3) != 0);
    endtask

    task automatic reconfigure_random();
        reconfigure(pick_reg_value(src_pkg::MAGIC_RESET),
                    pick_reg_value(src_pkg::VERSION_RESET),
                    pick_reg_value(src_pkg::FAN_RESET));
    endtask

    // Sends the record; a cut position changes the registers in mid-record.
    task automatic send_record(input int cut);
        for (int n = 0; n < src_pkg::RECORD_BYTES; n++)
        begin
            if (n == cut)
                reconfigure_random();
            send_byte(rec_word[n/4][8*(n%4) +: 8]);
        end
    endtask

    initial
    begin
        record_kind_t kind;
        int           cut;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records under the reset register values.
        set_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        seal_record(REC_GOOD);
        send_record(-1);
        set_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, src_pkg::FAN_RESET, 32'hFFFF_FFFF);
        seal_record(REC_GOOD);
        send_record(-1);
        // A fan word just over the limit fails, but the words still come out.
        set_settings(32'd12000, 32'd5000, 32'hFFFE_7960, 32'd13000, 32'd6000,
                     src_pkg::FAN_RESET + 1, 32'h0);
        seal_record(REC_FAN_HIGH);
        send_record(-1);
        fill_settings(REC_GOOD);
        seal_record(REC_BAD_CRC);
        send_record(-1);
        fill_settings(REC_GOOD);
        seal_record(REC_BAD_MAGIC);
        send_record(-1);
        fill_settings(REC_GOOD);
        seal_record(REC_BAD_VERSION);
        send_record(-1);

        // Register extremes, then a change in the middle of a record.
        reconfigure(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        fill_settings(REC_GOOD);
        seal_record(REC_GOOD);
        send_record(-1);
        reconfigure(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        fill_settings(REC_GOOD);
        rec_word[7] = 32'hFFFF_FFFF;
        seal_record(REC_GOOD);
        send_record(20);
        fill_settings(REC_GOOD);
        seal_record(REC_NOISE);
        send_record(-1);

        // Random records, mostly well formed, with register changes between
        // and sometimes inside records.
        for (int r = 0; r < RANDOM_RECORDS; r++)
        begin
            kind = pick_kind();
            fill_settings(kind);
            seal_record(kind);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, src_pkg::RECORD_BYTES - 1)
                                              : -1;
            send_record(cut);
            if (r % 6 == 5)
                reconfigure_random();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/src_pkg.sv
rtl/core/src_cfg_regs.sv
rtl/core/src_parse.sv
rtl/core/src_out_stage.sv
rtl/core/settings_record_checker.sv
test/record_result_checker.sv
test/settings_record_checker_tb.sv
